// ===== sv/tcp_splice_handshake_tracker_macros.svh =====
// assertion helpers shared by the tracker's modules
// each expects clk_i and rst_ni in the scope where it is used
`ifndef TCP_SPLICE_HANDSHAKE_TRACKER_MACROS_SVH
`define TCP_SPLICE_HANDSHAKE_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TST_ASSERT_IMP(lbl, ante, cons, msg)
`define TST_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/tst_pkg.sv =====
package tst_pkg;

  typedef enum logic [1:0] {
    OpSegment = 2'd0,
    OpConnect = 2'd1,
    OpRead    = 2'd2,
    OpFailure = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegClientAddr = 2'd0,
    RegClientPort = 2'd1,
    RegServerAddr = 2'd2,
    RegServerPort = 2'd3
  } reg_e;

  localparam logic [5:0] FlagFin = 6'h01;
  localparam logic [5:0] FlagSyn = 6'h02;
  localparam logic [5:0] FlagRst = 6'h04;
  localparam logic [5:0] FlagPsh = 6'h08;
  localparam logic [5:0] FlagAck = 6'h10;

  localparam logic [7:0] ProtoTcp = 8'd6;

  localparam int unsigned HeaderBytes = 40;
  localparam int unsigned BufferBytes = 65536;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // classified event word handed from front to back
  typedef struct packed {
    op_e         op;
    logic        seg_ours;
    logic        flag_rst;
    logic        flag_fin;
    logic        flag_syn;
    logic [31:0] seq;
    logic [31:0] seq_p1;
    logic [31:0] seq_end;
    logic [16:0] len;
    logic        len_nz;
    logic        oversize;
    logic        success;
    logic [31:0] rnd;
    logic [31:0] rnd_p1;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic        send_segment;
    logic [31:0] send_sequence;
    logic [31:0] send_acknowledge;
    logic [5:0]  send_flags;
    logic [16:0] send_length;
    logic        deliver_local;
    logic        shutdown_local;
    logic        start_reading;
    logic        close_connection;
  } res_t;

endpackage

// ===== sv/tst_front.sv =====
module tst_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [1:0]        op_i,
  input  logic              well_formed_i,
  input  logic [7:0]        ip_protocol_i,
  input  logic [31:0]       source_address_i,
  input  logic [31:0]       dest_address_i,
  input  logic [15:0]       source_port_i,
  input  logic [15:0]       dest_port_i,
  input  logic [5:0]        tcp_flags_i,
  input  logic [31:0]       sequence_number_i,
  input  logic [16:0]       data_length_i,
  input  logic              success_i,
  input  logic [31:0]       random_value_i,
  output tst_pkg::cmd_t     cmd_o
);

  logic [31:0] client_addr_q;
  logic [15:0] client_port_q;
  logic [31:0] server_addr_q;
  logic [15:0] server_port_q;
  logic [17:0] frame_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      client_addr_q <= '0;
      client_port_q <= '0;
      server_addr_q <= '0;
      server_port_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (tst_pkg::reg_e'(cfg_index_i))
        tst_pkg::RegClientAddr: client_addr_q <= cfg_data_i;
        tst_pkg::RegClientPort: client_port_q <= cfg_data_i[15:0];
        tst_pkg::RegServerAddr: server_addr_q <= cfg_data_i;
        tst_pkg::RegServerPort: server_port_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // header plus payload as it would sit in the send buffer
  assign frame_bytes = {1'b0, data_length_i} + 18'(tst_pkg::HeaderBytes);

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = tst_pkg::op_e'(op_i);
    cmd_o.seg_ours = well_formed_i && (ip_protocol_i == tst_pkg::ProtoTcp) &&
                     (source_address_i == client_addr_q) &&
                     (source_port_i == client_port_q) &&
                     (dest_address_i == server_addr_q) &&
                     (dest_port_i == server_port_q);
    cmd_o.flag_rst = |(tcp_flags_i & tst_pkg::FlagRst);
    cmd_o.flag_fin = |(tcp_flags_i & tst_pkg::FlagFin);
    cmd_o.flag_syn = |(tcp_flags_i & tst_pkg::FlagSyn);
    cmd_o.seq      = sequence_number_i;
    cmd_o.seq_p1   = sequence_number_i + 32'd1;
    cmd_o.seq_end  = sequence_number_i + 32'(data_length_i);
    cmd_o.len      = data_length_i;
    cmd_o.len_nz   = |data_length_i;
    cmd_o.oversize = frame_bytes > 18'(tst_pkg::BufferBytes);
    cmd_o.success  = success_i;
    cmd_o.rnd      = random_value_i;
    cmd_o.rnd_p1   = random_value_i + 32'd1;
  end

endmodule

// ===== sv/tst_cmd_queue.sv =====
`include "tcp_splice_handshake_tracker_macros.svh"

module tst_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  tst_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output tst_pkg::cmd_t rd_data_o
);

  localparam int unsigned PtrW = tst_pkg::QueuePtrW;
  localparam int unsigned CntW = PtrW + 1;

  tst_pkg::cmd_t   mem_q [tst_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr;
  logic            do_rd;

  assign full_o    = count_q == CntW'(tst_pkg::QueueDepth);
  assign valid_o   = count_q != '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_rd) begin
        rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `TST_ASSERT_IMP(a_cnt_bound, 1'b1, count_q <= CntW'(tst_pkg::QueueDepth), "queue overfilled")
  `TST_ASSERT_NXT(a_cnt_up, do_wr && !do_rd, count_q == $past(count_q) + 1'b1, "count lost a word")
  `TST_ASSERT_NXT(a_ptr_gap, do_rd && !do_wr && count_q == CntW'(1), wr_ptr_q == rd_ptr_q,
                  "pointers out of step when drained")

endmodule

// ===== sv/tst_back.sv =====
`include "tcp_splice_handshake_tracker_macros.svh"

module tst_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  tst_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tst_pkg::res_t res_o
);

  logic        closed_q, closed_d;
  logic        connected_q, connected_d;
  logic        synack_q, synack_d;
  logic        est_q, est_d;
  logic [31:0] cinit_q, cinit_d;
  logic [31:0] cinit_p1_q, cinit_p1_d;
  logic [31:0] cnext_q, cnext_d;
  logic [31:0] cacked_q, cacked_d;
  logic [31:0] sinit_q, sinit_d;
  logic [31:0] sinit_p1_q, sinit_p1_d;
  logic [31:0] snext_q, snext_d;

  logic          out_valid_q;
  tst_pkg::res_t res_q, res_d;
  logic          load;
  logic          seq_hit;
  logic [31:0]   rd_seq;
  logic [31:0]   rd_end;

  assign cmd_ready_o = !out_valid_q || pop_i;
  assign load        = cmd_valid_i && cmd_ready_o;
  assign empty_o     = !out_valid_q;
  assign res_o       = res_q;

  assign seq_hit = cmd_i.seq == cnext_q;
  // first data byte goes one past the initial sequence
  assign rd_seq  = (snext_q == sinit_q) ? sinit_p1_q : snext_q;
  assign rd_end  = rd_seq + 32'(cmd_i.len);

  always_comb begin
    closed_d    = closed_q;
    connected_d = connected_q;
    synack_d    = synack_q;
    est_d       = est_q;
    cinit_d     = cinit_q;
    cinit_p1_d  = cinit_p1_q;
    cnext_d     = cnext_q;
    cacked_d    = cacked_q;
    sinit_d     = sinit_q;
    sinit_p1_d  = sinit_p1_q;
    snext_d     = snext_q;
    res_d       = '0;

    if (!closed_q) begin
      unique case (cmd_i.op)
        tst_pkg::OpSegment: begin
          if (cmd_i.seg_ours) begin
            res_d.accepted = 1'b1;
            if (cmd_i.flag_rst) begin
              closed_d               = 1'b1;
              res_d.close_connection = 1'b1;
            end else if (cmd_i.flag_fin) begin
              res_d.shutdown_local = 1'b1;
              if (synack_q) begin
                res_d.send_segment     = 1'b1;
                res_d.send_sequence    = snext_q;
                res_d.send_acknowledge = cacked_q;
                res_d.send_flags       = tst_pkg::FlagFin | tst_pkg::FlagAck;
              end
            end else if (!cmd_i.flag_syn && est_q) begin
              if (cmd_i.len_nz) begin
                // out of order data is dropped
                if (seq_hit) begin
                  res_d.deliver_local = 1'b1;
                  cnext_d             = cmd_i.seq_end;
                  cacked_d            = cmd_i.seq_end;
                end
              end else if (!seq_hit) begin
                if (!synack_q || cmd_i.seq == cinit_p1_q) begin
                  cnext_d  = cmd_i.seq;
                  cacked_d = cmd_i.seq;
                end
              end else begin
                cacked_d = cnext_q;
              end
            end else if (cmd_i.flag_syn) begin
              cinit_d    = cmd_i.seq;
              cinit_p1_d = cmd_i.seq_p1;
              cnext_d    = cmd_i.seq_p1;
              cacked_d   = cmd_i.seq_p1;
              if (connected_q) begin
                res_d.send_segment     = 1'b1;
                res_d.send_acknowledge = cmd_i.seq_p1;
                res_d.send_flags       = tst_pkg::FlagSyn | tst_pkg::FlagAck;
                if (!synack_q) begin
                  sinit_d             = cmd_i.rnd;
                  sinit_p1_d          = cmd_i.rnd_p1;
                  snext_d             = cmd_i.rnd;
                  synack_d            = 1'b1;
                  est_d               = 1'b1;
                  res_d.start_reading = 1'b1;
                  res_d.send_sequence = cmd_i.rnd;
                end else begin
                  // retransmitted syn gets the original syn-ack again
                  res_d.send_sequence = sinit_q;
                end
              end
            end else if (synack_q) begin
              // third ack of the handshake, maybe carrying data
              est_d = 1'b1;
              if (cmd_i.len_nz) begin
                if (seq_hit) begin
                  res_d.deliver_local = 1'b1;
                  cnext_d             = cmd_i.seq_end;
                  cacked_d            = cmd_i.seq_end;
                end
              end else begin
                cacked_d = cnext_q;
              end
              res_d.start_reading = 1'b1;
            end
          end
        end
        tst_pkg::OpConnect: begin
          if (!cmd_i.success) begin
            closed_d               = 1'b1;
            res_d.close_connection = 1'b1;
          end else begin
            connected_d = 1'b1;
            // client syn already seen, answer it now
            if (!synack_q && (cinit_q != '0)) begin
              sinit_d                = cmd_i.rnd;
              sinit_p1_d             = cmd_i.rnd_p1;
              snext_d                = cmd_i.rnd;
              synack_d               = 1'b1;
              res_d.send_segment     = 1'b1;
              res_d.send_sequence    = cmd_i.rnd;
              res_d.send_acknowledge = cinit_p1_q;
              res_d.send_flags       = tst_pkg::FlagSyn | tst_pkg::FlagAck;
            end
            res_d.start_reading = 1'b1;
          end
        end
        tst_pkg::OpRead: begin
          if (!cmd_i.success || !cmd_i.len_nz) begin
            if (synack_q) begin
              res_d.send_segment     = 1'b1;
              res_d.send_sequence    = snext_q;
              res_d.send_acknowledge = cacked_q;
              res_d.send_flags       = tst_pkg::FlagFin | tst_pkg::FlagAck;
            end
            closed_d               = 1'b1;
            res_d.close_connection = 1'b1;
          end else if (!synack_q || cmd_i.oversize) begin
            closed_d               = 1'b1;
            res_d.close_connection = 1'b1;
          end else begin
            res_d.send_segment     = 1'b1;
            res_d.send_sequence    = rd_seq;
            res_d.send_acknowledge = cacked_q;
            res_d.send_flags       = tst_pkg::FlagPsh | tst_pkg::FlagAck;
            res_d.send_length      = cmd_i.len;
            snext_d                = rd_end;
            res_d.start_reading    = 1'b1;
          end
        end
        tst_pkg::OpFailure: begin
          closed_d               = 1'b1;
          res_d.close_connection = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q    <= 1'b0;
      connected_q <= 1'b0;
      synack_q    <= 1'b0;
      est_q       <= 1'b0;
      cinit_q     <= '0;
      cinit_p1_q  <= 32'd1;
      cnext_q     <= '0;
      cacked_q    <= '0;
      sinit_q     <= '0;
      sinit_p1_q  <= 32'd1;
      snext_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        closed_q    <= closed_d;
        connected_q <= connected_d;
        synack_q    <= synack_d;
        est_q       <= est_d;
        cinit_q     <= cinit_d;
        cinit_p1_q  <= cinit_p1_d;
        cnext_q     <= cnext_d;
        cacked_q    <= cacked_d;
        sinit_q     <= sinit_d;
        sinit_p1_q  <= sinit_p1_d;
        snext_q     <= snext_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  `TST_ASSERT_NXT(a_closed_sticky, closed_q, closed_q, "closed connection reopened")
  `TST_ASSERT_NXT(a_closed_quiet, load && closed_q,
                  !res_q.accepted && !res_q.send_segment && !res_q.start_reading,
                  "closed connection produced a command")
  `TST_ASSERT_IMP(a_send_has_ack, out_valid_q && res_q.send_segment,
                  res_q.send_flags[4], "sent segment without ack flag")

endmodule

// ===== sv/tcp_splice_handshake_tracker.sv =====
// Server side of one spliced TCP connection. Events (tunnel segment, local
// connect result, local read result, failure) are pushed in as words and each
// yields exactly one result word, in order, popped from the result side. The
// front compares the segment tuple against the four configuration registers
// and precomputes sums; a two-word queue then feeds the back, which updates
// the handshake flags and sequence numbers and parks the result in an output
// register. One event is taken per clock while full is low; while results
// are not popped the queue absorbs two more events before full rises. The
// user must write configuration only while no event is in flight; the block
// itself does not enforce this. cfg_ready_o is always high.
module tcp_splice_handshake_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic        well_formed_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [5:0]  tcp_flags_i,
  input  logic [31:0] sequence_number_i,
  input  logic [16:0] data_length_i,
  input  logic        success_i,
  input  logic [31:0] random_value_i,
  output logic        empty,
  input  logic        pop,
  output logic        accepted_o,
  output logic        send_segment_o,
  output logic [31:0] send_sequence_o,
  output logic [31:0] send_acknowledge_o,
  output logic [5:0]  send_flags_o,
  output logic [16:0] send_length_o,
  output logic        deliver_local_o,
  output logic        shutdown_local_o,
  output logic        start_reading_o,
  output logic        close_connection_o
);

  tst_pkg::cmd_t front_cmd;
  tst_pkg::cmd_t back_cmd;
  tst_pkg::res_t res;
  logic          back_valid;
  logic          back_ready;

  assign cfg_ready_o = 1'b1;

  tst_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .well_formed_i     (well_formed_i),
    .ip_protocol_i     (ip_protocol_i),
    .source_address_i  (source_address_i),
    .dest_address_i    (dest_address_i),
    .source_port_i     (source_port_i),
    .dest_port_i       (dest_port_i),
    .tcp_flags_i       (tcp_flags_i),
    .sequence_number_i (sequence_number_i),
    .data_length_i     (data_length_i),
    .success_i         (success_i),
    .random_value_i    (random_value_i),
    .cmd_o             (front_cmd)
  );

  tst_cmd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (back_ready),
    .valid_o   (back_valid),
    .rd_data_o (back_cmd)
  );

  tst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_i       (back_cmd),
    .cmd_ready_o (back_ready),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign accepted_o         = res.accepted;
  assign send_segment_o     = res.send_segment;
  assign send_sequence_o    = res.send_sequence;
  assign send_acknowledge_o = res.send_acknowledge;
  assign send_flags_o       = res.send_flags;
  assign send_length_o      = res.send_length;
  assign deliver_local_o    = res.deliver_local;
  assign shutdown_local_o   = res.shutdown_local;
  assign start_reading_o    = res.start_reading;
  assign close_connection_o = res.close_connection;

endmodule

// ===== sim/tcp_splice_handshake_tracker_tb.sv =====
`timescale 1ns / 1ps

module tcp_splice_handshake_tracker_tb;

  localparam logic [5:0] FlagUrg = 6'h20;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam int unsigned ReadMax = tst_pkg::BufferBytes - tst_pkg::HeaderBytes;
  localparam int PhaseWords = 210;
  localparam int Phases = 5;

  typedef struct packed {
    tst_pkg::op_e op;
    logic        well_formed;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  flags;
    logic [31:0] seq;
    logic [16:0] len;
    logic        success;
    logic [31:0] rnd;
  } ev_word_t;

  typedef struct packed {
    ev_word_t      ev;
    logic          typed;
    tst_pkg::res_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op_i = '0;
  logic        well_formed_i = 1'b0;
  logic [7:0]  ip_protocol_i = '0;
  logic [31:0] source_address_i = '0;
  logic [31:0] dest_address_i = '0;
  logic [15:0] source_port_i = '0;
  logic [15:0] dest_port_i = '0;
  logic [5:0]  tcp_flags_i = '0;
  logic [31:0] sequence_number_i = '0;
  logic [16:0] data_length_i = '0;
  logic        success_i = 1'b0;
  logic [31:0] random_value_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        accepted_o;
  logic        send_segment_o;
  logic [31:0] send_sequence_o;
  logic [31:0] send_acknowledge_o;
  logic [5:0]  send_flags_o;
  logic [16:0] send_length_o;
  logic        deliver_local_o;
  logic        shutdown_local_o;
  logic        start_reading_o;
  logic        close_connection_o;

  tcp_splice_handshake_tracker DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .push               (push),
    .full               (full),
    .op_i               (op_i),
    .well_formed_i      (well_formed_i),
    .ip_protocol_i      (ip_protocol_i),
    .source_address_i   (source_address_i),
    .dest_address_i     (dest_address_i),
    .source_port_i      (source_port_i),
    .dest_port_i        (dest_port_i),
    .tcp_flags_i        (tcp_flags_i),
    .sequence_number_i  (sequence_number_i),
    .data_length_i      (data_length_i),
    .success_i          (success_i),
    .random_value_i     (random_value_i),
    .empty              (empty),
    .pop                (pop),
    .accepted_o         (accepted_o),
    .send_segment_o     (send_segment_o),
    .send_sequence_o    (send_sequence_o),
    .send_acknowledge_o (send_acknowledge_o),
    .send_flags_o       (send_flags_o),
    .send_length_o      (send_length_o),
    .deliver_local_o    (deliver_local_o),
    .shutdown_local_o   (shutdown_local_o),
    .start_reading_o    (start_reading_o),
    .close_connection_o (close_connection_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // connection tracker mirror
  bit [31:0] cfg_cli_addr;
  bit [15:0] cfg_cli_port;
  bit [31:0] cfg_srv_addr;
  bit [15:0] cfg_srv_port;
  bit        conn_closed;
  bit        connected;
  bit        synack_done;
  bit        established;
  bit [31:0] cli_isn;
  bit [31:0] cli_nxt;
  bit [31:0] cli_ack;
  bit [31:0] srv_isn;
  bit [31:0] srv_nxt;

  tst_pkg::res_t expected_results[$];
  int            mismatches = 0;

  function automatic tst_pkg::res_t with_header(input tst_pkg::res_t r,
                                                input logic [31:0] sq,
                                                input logic [31:0] ack,
                                                input logic [5:0] fl,
                                                input logic [16:0] ln);
    tst_pkg::res_t o;
    o = r;
    o.send_segment = 1'b1;
    o.send_sequence = sq;
    o.send_acknowledge = ack;
    o.send_flags = fl;
    o.send_length = ln;
    return o;
  endfunction

  function automatic tst_pkg::res_t first_synack(input tst_pkg::res_t r,
                                                 input logic [31:0] rnd);
    srv_isn = rnd;
    srv_nxt = rnd;
    synack_done = 1'b1;
    return with_header(r, rnd, cli_isn + 32'd1, tst_pkg::FlagSyn | tst_pkg::FlagAck, '0);
  endfunction

  function automatic tst_pkg::res_t take_payload(input tst_pkg::res_t r, input ev_word_t ev);
    tst_pkg::res_t o;
    o = r;
    if (ev.seq == cli_nxt) begin
      o.deliver_local = 1'b1;
      cli_nxt = ev.seq + 32'(ev.len);
      cli_ack = cli_nxt;
    end
    return o;
  endfunction

  function automatic tst_pkg::res_t track_event(input ev_word_t ev);
    tst_pkg::res_t r;
    logic [31:0] out_seq;
    r = '0;
    if (conn_closed) return r;
    case (ev.op)
      tst_pkg::OpSegment: begin
        if (!ev.well_formed || ev.ip_protocol != tst_pkg::ProtoTcp ||
            ev.src_addr != cfg_cli_addr || ev.src_port != cfg_cli_port ||
            ev.dst_addr != cfg_srv_addr || ev.dst_port != cfg_srv_port) return r;
        r.accepted = 1'b1;
        if ((ev.flags & tst_pkg::FlagRst) != 0) begin
          conn_closed = 1'b1;
          r.close_connection = 1'b1;
        end else if ((ev.flags & tst_pkg::FlagFin) != 0) begin
          r.shutdown_local = 1'b1;
          if (synack_done)
            r = with_header(r, srv_nxt, cli_ack, tst_pkg::FlagFin | tst_pkg::FlagAck, '0);
        end else if ((ev.flags & tst_pkg::FlagSyn) == 0 && established) begin
          if (ev.len != 0) begin
            r = take_payload(r, ev);
          end else if (ev.seq != cli_nxt) begin
            // a bare ack rewinds only to just past the client syn
            if (!synack_done || ev.seq == cli_isn + 32'd1) begin
              cli_nxt = ev.seq;
              cli_ack = ev.seq;
            end
          end else begin
            cli_ack = cli_nxt;
          end
        end else if ((ev.flags & tst_pkg::FlagSyn) != 0) begin
          cli_isn = ev.seq;
          cli_nxt = ev.seq + 32'd1;
          cli_ack = cli_nxt;
          if (connected) begin
            if (!synack_done) begin
              r = first_synack(r, ev.rnd);
              established = 1'b1;
              r.start_reading = 1'b1;
            end else begin
              r = with_header(r, srv_isn, cli_isn + 32'd1,
                              tst_pkg::FlagSyn | tst_pkg::FlagAck, '0);
            end
          end
        end else if (synack_done) begin
          established = 1'b1;
          if (ev.len != 0) r = take_payload(r, ev);
          else cli_ack = cli_nxt;
          r.start_reading = 1'b1;
        end
      end
      tst_pkg::OpConnect: begin
        if (!ev.success) begin
          conn_closed = 1'b1;
          r.close_connection = 1'b1;
        end else begin
          connected = 1'b1;
          if (!synack_done && cli_isn != 0) r = first_synack(r, ev.rnd);
          r.start_reading = 1'b1;
        end
      end
      tst_pkg::OpRead: begin
        if (!ev.success || ev.len == 0) begin
          if (synack_done)
            r = with_header(r, srv_nxt, cli_ack, tst_pkg::FlagFin | tst_pkg::FlagAck, '0);
          conn_closed = 1'b1;
          r.close_connection = 1'b1;
        end else if (!synack_done ||
                     tst_pkg::HeaderBytes + 32'(ev.len) > tst_pkg::BufferBytes) begin
          conn_closed = 1'b1;
          r.close_connection = 1'b1;
        end else begin
          // first data after the syn-ack skips the syn's sequence slot
          out_seq = (srv_nxt == srv_isn) ? srv_isn + 32'd1 : srv_nxt;
          r = with_header(r, out_seq, cli_ack, tst_pkg::FlagPsh | tst_pkg::FlagAck, ev.len);
          srv_nxt = out_seq + 32'(ev.len);
          r.start_reading = 1'b1;
        end
      end
      default: begin
        conn_closed = 1'b1;
        r.close_connection = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic string word_text(input tst_pkg::res_t r);
    return $sformatf("acc=%b snd=%b seq=%h ack=%h flg=%h len=%h dlv=%b shut=%b rd=%b cls=%b",
                     r.accepted, r.send_segment, r.send_sequence, r.send_acknowledge,
                     r.send_flags, r.send_length, r.deliver_local, r.shutdown_local,
                     r.start_reading, r.close_connection);
  endfunction

  always @(posedge clk_i) begin : result_check
    tst_pkg::res_t seen;
    tst_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      seen = {accepted_o, send_segment_o, send_sequence_o, send_acknowledge_o, send_flags_o,
              send_length_o, deliver_local_o, shutdown_local_o, start_reading_o,
              close_connection_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", word_text(seen));
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t", $time);
            $display("  expected %s", word_text(want));
            $display("  actual   %s", word_text(seen));
          end
        end
      end
    end
  end

  function automatic int pause_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
  endfunction

  initial begin : result_drain
    int  stall_left;
    int  window_left;
    int  popped;
    bit  steady;
    stall_left = 0;
    window_left = 0;
    popped = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk_i);
      if (window_left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        window_left = 64;
      end
      window_left--;
      if (pop && !empty) begin
        popped++;
        // long hold-off so the sender backs up and full rises
        if (popped % 400 == 200) stall_left = 150;
      end
      if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0)
        stall_left = pause_length();
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic ev_word_t base_word(input tst_pkg::op_e op);
    ev_word_t w;
    w.op = op;
    w.well_formed = 1'b1;
    w.ip_protocol = tst_pkg::ProtoTcp;
    w.src_addr = cfg_cli_addr;
    w.dst_addr = cfg_srv_addr;
    w.src_port = cfg_cli_port;
    w.dst_port = cfg_srv_port;
    w.flags = 6'($urandom);
    w.seq = $urandom;
    w.len = 17'($urandom);
    w.success = 1'b1;
    w.rnd = $urandom;
    return w;
  endfunction

  function automatic ev_word_t random_event(output bit foreign);
    ev_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    foreign = 1'b0;
    w = base_word(tst_pkg::OpSegment);
    if (pick < 15) begin
      foreign = 1'b1;
      w.well_formed = 1'($urandom);
      w.ip_protocol = 8'($urandom);
      w.src_addr = $urandom;
      w.dst_addr = $urandom;
      w.src_port = 16'($urandom);
      w.dst_port = 16'($urandom);
      w.success = 1'($urandom);
      case ($urandom_range(0, 2))
        0: w.well_formed = 1'b0;
        1: if (w.ip_protocol == tst_pkg::ProtoTcp) w.ip_protocol = ~tst_pkg::ProtoTcp;
        default: begin
          w.src_addr = cfg_cli_addr;
          w.dst_addr = cfg_srv_addr;
          w.src_port = cfg_cli_port;
          w.dst_port = cfg_srv_port;
          case ($urandom_range(0, 3))
            0: w.src_addr[$urandom_range(0, 31)] ^= 1'b1;
            1: w.dst_addr[$urandom_range(0, 31)] ^= 1'b1;
            2: w.src_port[$urandom_range(0, 15)] ^= 1'b1;
            default: w.dst_port[$urandom_range(0, 15)] ^= 1'b1;
          endcase
        end
      endcase
    end else if (pick < 45) begin
      w.flags = tst_pkg::FlagAck | ($urandom_range(0, 1) ? tst_pkg::FlagPsh : '0) |
                ($urandom_range(0, 3) == 0 ? FlagUrg : '0);
      w.seq = cli_nxt;
      w.len = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(1, 65536)) :
                                            17'($urandom_range(1, 1460));
    end else if (pick < 50) begin
      w.flags = tst_pkg::FlagAck | tst_pkg::FlagPsh;
      w.len = 17'($urandom_range(1, 1460));
    end else if (pick < 60) begin
      w.flags = tst_pkg::FlagAck;
      w.len = '0;
      case ($urandom_range(0, 4))
        0: w.seq = cli_isn + 32'd1;
        1: w.seq = $urandom;
        default: w.seq = cli_nxt;
      endcase
    end else if (pick < 64) begin
      w.flags = tst_pkg::FlagFin | tst_pkg::FlagAck;
      w.seq = cli_nxt;
    end else if (pick < 66) begin
      w.flags = tst_pkg::FlagSyn;
      w.len = '0;
    end else if (pick < 98) begin
      w = base_word(tst_pkg::OpRead);
      w.len = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(1, ReadMax)) :
                                            17'($urandom_range(1, 1460));
    end else begin
      w = base_word(tst_pkg::OpConnect);
    end
    return w;
  endfunction

  task automatic apply_config(input logic [31:0] cli_a, input logic [15:0] cli_p,
                              input logic [31:0] srv_a, input logic [15:0] srv_p);
    tst_pkg::reg_e idx;
    for (int i = 0; i < 4; i++) begin
      idx = tst_pkg::reg_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      // port registers take the low half only
      case (idx)
        tst_pkg::RegClientAddr: cfg_data_i <= cli_a;
        tst_pkg::RegClientPort: cfg_data_i <= {16'($urandom), cli_p};
        tst_pkg::RegServerAddr: cfg_data_i <= srv_a;
        default:                cfg_data_i <= {16'($urandom), srv_p};
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cfg_cli_addr = cli_a;
    cfg_cli_port = cli_p;
    cfg_srv_addr = srv_a;
    cfg_srv_port = srv_p;
  endtask

  task automatic drive_event(input ev_word_t ev, input int gap, input logic typed,
                             input tst_pkg::res_t want);
    tst_pkg::res_t predicted;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= ev.op;
    well_formed_i <= ev.well_formed;
    ip_protocol_i <= ev.ip_protocol;
    source_address_i <= ev.src_addr;
    dest_address_i <= ev.dst_addr;
    source_port_i <= ev.src_port;
    dest_port_i <= ev.dst_port;
    tcp_flags_i <= ev.flags;
    sequence_number_i <= ev.seq;
    data_length_i <= ev.len;
    success_i <= ev.success;
    random_value_i <= ev.rnd;
    do @(posedge clk_i); while (full);
    predicted = track_event(ev);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  plan_row_t plan[$];

  task automatic add_row(input ev_word_t ev, input logic typed, input tst_pkg::res_t want);
    plan_row_t row;
    row.ev = ev;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  initial begin : stimulus
    ev_word_t      w;
    tst_pkg::res_t acc_only;
    tst_pkg::res_t acc_shut;
    logic [31:0]   ca;
    logic [31:0]   sa;
    logic [15:0]   cp;
    logic [15:0]   sp;
    bit            foreign;
    bit            steady;
    int            useful;
    int            item_count;

    steady = 1'b0;
    item_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    ca = $urandom;
    cp = 16'($urandom);
    sa = $urandom;
    sp = 16'($urandom);
    apply_config(ca, cp, sa, sp);

    acc_only = '0;
    acc_only.accepted = 1'b1;
    acc_shut = acc_only;
    acc_shut.shutdown_local = 1'b1;

    // foreign segments are dropped whole
    w = base_word(tst_pkg::OpSegment); w.well_formed = 1'b0; add_row(w, 1'b1, '0);
    w = base_word(tst_pkg::OpSegment); w.ip_protocol = ProtoUdp; add_row(w, 1'b1, '0);
    w = base_word(tst_pkg::OpSegment); w.src_addr = ~ca; add_row(w, 1'b1, '0);
    w = base_word(tst_pkg::OpSegment); w.src_port = ~cp; add_row(w, 1'b1, '0);
    w = base_word(tst_pkg::OpSegment); w.dst_addr = ~sa; add_row(w, 1'b1, '0);
    w = base_word(tst_pkg::OpSegment); w.dst_port = ~sp; add_row(w, 1'b1, '0);
    // handshake not started yet
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagAck; add_row(w, 1'b1, acc_only);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagFin; add_row(w, 1'b1, acc_shut);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagSyn; w.seq = '1;
    add_row(w, 1'b1, acc_only);
    // connect answers the pending syn, sequence wraps to zero
    w = base_word(tst_pkg::OpConnect); w.rnd = '1; add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagSyn; w.seq = '1;
    add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagAck; w.seq = '0; w.len = '0;
    add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagPsh | tst_pkg::FlagAck;
    w.seq = '0; w.len = 17'h10000;
    add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagAck; w.seq = 32'h8000_0000;
    w.len = 17'd1;
    add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagAck; w.seq = '0; w.len = '0;
    add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpRead); w.len = 17'd1; add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpRead); w.len = 17'(ReadMax); add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagFin | tst_pkg::FlagAck;
    add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpConnect); add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpSegment);
    w.flags = FlagUrg | tst_pkg::FlagPsh | tst_pkg::FlagAck; w.seq = '0;
    w.len = 17'd1; add_row(w, 1'b0, '0);
    w = base_word(tst_pkg::OpSegment); w.flags = tst_pkg::FlagAck; w.len = '0;
    add_row(w, 1'b0, '0);

    foreach (plan[i])
      drive_event(plan[i].ev, $urandom_range(0, 1) ? 0 : pause_length(), plan[i].typed,
                  plan[i].want);

    for (int phase = 0; phase < Phases; phase++) begin
      settle();
      case (phase)
        0: apply_config('1, '1, '1, '1);
        1: apply_config('0, '0, '0, '0);
        default: apply_config($urandom, 16'($urandom), $urandom, 16'($urandom));
      endcase
      useful = 0;
      while (useful < PhaseWords) begin
        if (item_count % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        item_count++;
        w = random_event(foreign);
        drive_event(w, (steady || $urandom_range(0, 1)) ? 0 : pause_length(), 1'b0, '0);
        if (!foreign) useful++;
      end
    end

    // one teardown, picked at random, then everything is ignored
    w = base_word(tst_pkg::OpSegment);
    case ($urandom_range(0, 5))
      0: w.flags = w.flags | tst_pkg::FlagRst;
      1: w.op = tst_pkg::OpFailure;
      2: begin
        w.op = tst_pkg::OpConnect;
        w.success = 1'b0;
      end
      3: begin
        w.op = tst_pkg::OpRead;
        w.success = 1'b0;
      end
      4: begin
        w.op = tst_pkg::OpRead;
        w.len = '0;
      end
      default: begin
        w.op = tst_pkg::OpRead;
        w.len = 17'($urandom_range(ReadMax + 1, 17'h1FFFF));
      end
    endcase
    drive_event(w, pause_length(), 1'b0, '0);
    for (int i = 0; i < 4; i++) begin
      w = base_word(tst_pkg::op_e'(i));
      drive_event(w, 0, 1'b1, '0);
    end
    settle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
